// File: src/csfw_pkg.sv
// ---------------------------------------------------------------------------
// csfw_pkg: shared types and codes for the counting semaphore
// Request/response structs, outcome codes and register indexes.
// ---------------------------------------------------------------------------
package csfw_pkg;

  localparam int unsigned QueueDepthDef = 8;

  localparam int unsigned CountW = 8;
  localparam int unsigned TaskW  = 4;
  localparam int unsigned CfgIdxW = 2;

  // opcodes
  localparam logic OP_WAIT   = 1'b0;
  localparam logic OP_SIGNAL = 1'b1;

  // outcome codes
  localparam logic [2:0] OUT_GRANTED    = 3'd0;
  localparam logic [2:0] OUT_BLOCKED    = 3'd1;
  localparam logic [2:0] OUT_QUEUE_FULL = 3'd2;
  localparam logic [2:0] OUT_WOKE       = 3'd3;
  localparam logic [2:0] OUT_RAISED     = 3'd4;
  localparam logic [2:0] OUT_COUNT_FULL = 3'd5;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_INITIAL_COUNT = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_COUNT     = 2'd1;

  localparam logic [CountW-1:0] INITIAL_COUNT_RST = 8'd0;
  localparam logic [CountW-1:0] MAX_COUNT_RST     = 8'd1;

  typedef struct packed {
    logic             opcode;
    logic [TaskW-1:0] task_id;
  } req_t;

  typedef struct packed {
    logic             ok;
    logic [2:0]       outcome;
    logic [TaskW-1:0] task_out;
    logic             reschedule;
  } rsp_t;

endpackage

// File: src/counting_semaphore_fifo_wait.sv
// ---------------------------------------------------------------------------
// counting_semaphore_fifo_wait: counting semaphore with FIFO of waiters
// Wait takes a unit, queues the task or is refused; signal wakes the oldest
// waiter, raises the count or is refused. Waiter queue in a sync RAM.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------
//  in      | in        | in_valid / in_stall  | in_req  (opcode, task_id)
//  out     | out       | out_valid / out_stall| out_rsp (ok, outcome,
//          |           |                      |          task_out, resched)
//  cfg     | in        | cfg_valid / cfg_ready| cfg_index, cfg_wdata
//
// One request per cycle sustained while the output is not stalled; each
// request's response is registered in the decided stage (decide + RAM
// read), then in the output register. The waiter RAM read is registered.
// Reset (sync, active low) clears count to min(initial, max) = 0 and
// empties the queue; the RAM itself is not cleared.
// A stalled output holds; the request side stalls only while a decided
// request cannot move into the output register.
module counting_semaphore_fifo_wait #(
  parameter int unsigned QUEUE_DEPTH = csfw_pkg::QueueDepthDef
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  csfw_pkg::req_t                    in_req,
  output logic                              out_valid,
  input  logic                              out_stall,
  output csfw_pkg::rsp_t                    out_rsp,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [csfw_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [csfw_pkg::CountW-1:0]       cfg_wdata
);
  import csfw_pkg::*;

  localparam int unsigned PtrW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned WaitW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0]  PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [WaitW-1:0] WaitFull = WaitW'(QUEUE_DEPTH);

  // config and control state
  logic [CountW-1:0] init_cnt_r, max_cnt_r, avail_r, avail_nxt;
  logic [PtrW-1:0]   head_r, head_nxt, tail_r, tail_nxt;
  logic [WaitW-1:0]  waiting_r, waiting_nxt;

  // waiter RAM
  logic [TaskW-1:0]  wait_mem [QUEUE_DEPTH];
  logic [TaskW-1:0]  mem_rd_r;
  logic              mem_we;

  // decided-request stage (waits for RAM read data)
  logic              pend_v_r;
  logic              pend_wake_r;
  rsp_t              pend_rsp_r;
  rsp_t              pend_out;
  rsp_t              dec_rsp;
  logic              dec_wake;

  // output register
  logic              out_v_r;
  rsp_t              out_rsp_r;

  logic in_acc, pend_move, cfg_wr;
  logic [CountW-1:0] init_new, max_new, reload;

  assign pend_move = pend_v_r & (~out_v_r | ~out_stall);
  assign in_stall  = pend_v_r & ~pend_move;
  assign in_acc    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready &
                     ((cfg_index == REG_INITIAL_COUNT) || (cfg_index == REG_MAX_COUNT));

  assign out_valid = out_v_r;
  assign out_rsp   = out_rsp_r;

  // new register values and reload count
  always_comb begin
    init_new = init_cnt_r;
    max_new  = max_cnt_r;
    if (cfg_index == REG_INITIAL_COUNT) begin
      init_new = cfg_wdata;
    end else begin
      max_new = cfg_wdata;
    end
    reload = (init_new > max_new) ? max_new : init_new;
  end

  // decide the request from the control registers
  always_comb begin
    avail_nxt   = avail_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    waiting_nxt = waiting_r;
    mem_we      = 1'b0;
    dec_wake    = 1'b0;
    dec_rsp     = '0;
    if (in_req.opcode == OP_WAIT) begin
      if (avail_r != '0) begin
        avail_nxt       = avail_r - 1'b1;
        dec_rsp.ok      = 1'b1;
        dec_rsp.outcome = OUT_GRANTED;
      end else if (waiting_r >= WaitFull) begin
        dec_rsp.outcome = OUT_QUEUE_FULL;
      end else begin
        mem_we             = in_acc;
        tail_nxt           = (tail_r == PtrLast) ? '0 : tail_r + 1'b1;
        waiting_nxt        = waiting_r + 1'b1;
        dec_rsp.ok         = 1'b1;
        dec_rsp.outcome    = OUT_BLOCKED;
        dec_rsp.task_out   = in_req.task_id;
        dec_rsp.reschedule = 1'b1;
      end
    end else begin
      if (waiting_r != '0) begin
        // task_out filled from the RAM read next cycle
        dec_wake           = 1'b1;
        head_nxt           = (head_r == PtrLast) ? '0 : head_r + 1'b1;
        waiting_nxt        = waiting_r - 1'b1;
        dec_rsp.ok         = 1'b1;
        dec_rsp.outcome    = OUT_WOKE;
        dec_rsp.reschedule = 1'b1;
      end else if (avail_r < max_cnt_r) begin
        avail_nxt       = avail_r + 1'b1;
        dec_rsp.ok      = 1'b1;
        dec_rsp.outcome = OUT_RAISED;
      end else begin
        dec_rsp.outcome = OUT_COUNT_FULL;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_cnt_r <= INITIAL_COUNT_RST;
      max_cnt_r  <= MAX_COUNT_RST;
      avail_r    <= '0;
      head_r     <= '0;
      tail_r     <= '0;
      waiting_r  <= '0;
    end else if (cfg_wr) begin
      init_cnt_r <= init_new;
      max_cnt_r  <= max_new;
      avail_r    <= reload;
      head_r     <= '0;
      tail_r     <= '0;
      waiting_r  <= '0;
    end else if (in_acc) begin
      avail_r   <= avail_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      waiting_r <= waiting_nxt;
    end
  end

  // waiter RAM: write at tail, read at head (a wake never meets a same-cycle
  // write to its entry, so no bypass is needed)
  always_ff @(posedge clk) begin
    if (mem_we) begin
      wait_mem[tail_r] <= in_req.task_id;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem_rd_r <= wait_mem[head_r];
    end
  end

  // decided stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (in_acc) begin
      pend_v_r <= 1'b1;
    end else if (pend_move) begin
      pend_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pend_rsp_r  <= dec_rsp;
      pend_wake_r <= dec_wake;
    end
  end

  // merge the woken task from the RAM read
  always_comb begin
    pend_out = pend_rsp_r;
    if (pend_wake_r) begin
      pend_out.task_out = mem_rd_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (pend_move) begin
      out_v_r <= 1'b1;
    end else if (~out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_move) begin
      out_rsp_r <= pend_out;
    end
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for counting_semaphore_fifo_wait
// Runs directed wait/signal requests, then random bursts under several
// register settings and idling mixes. A scoreboard predicts every response.
// ---------------------------------------------------------------------------
module tb;
  import csfw_pkg::*;

  localparam int unsigned QDepth      = QueueDepthDef;
  localparam int unsigned SegItems    = 67;   // random requests per setting
  localparam int unsigned NumOutcomes = 6;
  localparam int unsigned MaxReports  = 10;

  // Indexes the block has no register behind; writes there must be ignored.
  localparam logic [CfgIdxW-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SPARE_B = 2'd3;

  // -------------------------------------------------------------------------
  // Scoreboard: own copy of the semaphore, the waiter FIFO and the registers.
  // Each accepted request pushes the response it must produce; each accepted
  // response is checked against the oldest one still owed.
  // -------------------------------------------------------------------------
  class sem_scoreboard;
    logic [CountW-1:0] init_cnt;
    logic [CountW-1:0] max_cnt;
    logic [CountW-1:0] avail;
    logic [TaskW-1:0]  waiters [QDepth];
    int                head;
    int                tail;
    int                waiting;
    rsp_t              owed_rsps [$];
    int                mismatches;
    int                checked;
    int                seen [NumOutcomes];

    function new();
      init_cnt   = INITIAL_COUNT_RST;
      max_cnt    = MAX_COUNT_RST;
      mismatches = 0;
      checked    = 0;
      foreach (seen[i]) seen[i] = 0;
      reload();
    endfunction

    // Count reloads clamped to the maximum; the FIFO empties.
    function void reload();
      avail   = (init_cnt > max_cnt) ? max_cnt : init_cnt;
      head    = 0;
      tail    = 0;
      waiting = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CountW-1:0] data);
      case (idx)
        REG_INITIAL_COUNT: init_cnt = data;
        REG_MAX_COUNT:     max_cnt  = data;
        default:           return;
      endcase
      reload();
    endfunction

    function void note_request(req_t r);
      rsp_t want;
      want = '0;
      if (r.opcode == OP_WAIT) begin
        if (avail != 0) begin
          avail        = avail - 1'b1;
          want.ok      = 1'b1;
          want.outcome = OUT_GRANTED;
        end else if (waiting >= QDepth) begin
          want.outcome = OUT_QUEUE_FULL;
        end else begin
          waiters[tail]   = r.task_id;
          tail            = (tail + 1) % QDepth;
          waiting++;
          want.ok         = 1'b1;
          want.outcome    = OUT_BLOCKED;
          want.task_out   = r.task_id;
          want.reschedule = 1'b1;
        end
      end else begin
        // a waiter always wins over raising the count
        if (waiting > 0) begin
          want.task_out   = waiters[head];
          head            = (head + 1) % QDepth;
          waiting--;
          want.ok         = 1'b1;
          want.outcome    = OUT_WOKE;
          want.reschedule = 1'b1;
        end else if (avail < max_cnt) begin
          avail        = avail + 1'b1;
          want.ok      = 1'b1;
          want.outcome = OUT_RAISED;
        end else begin
          want.outcome = OUT_COUNT_FULL;
        end
      end
      owed_rsps.push_back(want);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (owed_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: response with no request owed: ok=%0b outcome=%0d task=%0d resched=%0b",
                   $time, got.ok, got.outcome, got.task_out, got.reschedule);
        return;
      end
      want = owed_rsps.pop_front();
      checked++;
      seen[want.outcome]++;
      if (got.ok !== want.ok || got.outcome !== want.outcome ||
          got.task_out !== want.task_out || got.reschedule !== want.reschedule) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("%0t: response %0d mismatch", $time, checked);
          $display("  expected ok=%0b outcome=%0d task=%0d resched=%0b",
                   want.ok, want.outcome, want.task_out, want.reschedule);
          $display("  actual   ok=%0b outcome=%0d task=%0d resched=%0b",
                   got.ok, got.outcome, got.task_out, got.reschedule);
        end
      end
    endfunction

    function int pending();
      return owed_rsps.size();
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // DUT and its signals; every input starts at a known value.
  // -------------------------------------------------------------------------
  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  req_t                in_req    = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  rsp_t                out_rsp;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CountW-1:0]   cfg_wdata = '0;

  int send_idle_pct = 0;   // chance the request side idles in a cycle
  int stall_pct     = 0;   // chance the response side stalls in a cycle

  sem_scoreboard sb = new();

  counting_semaphore_fifo_wait dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Response side back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Monitor: everything is sampled at the edge, before the NBA updates land,
  // so register writes, responses and requests are seen exactly as the DUT
  // takes them. Responses lag requests, so the order here does not matter.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_wdata);
      if (out_valid && !out_stall) sb.check_response(out_rsp);
      if (in_valid && !in_stall) sb.note_request(in_req);
    end
  end

  // -------------------------------------------------------------------------
  // Drivers
  // -------------------------------------------------------------------------
  // Holds the request until the edge that takes it; valid stays high on
  // return so back-to-back requests need no extra assignment.
  task automatic send_request(input logic op, input logic [TaskW-1:0] id);
    in_valid       <= 1'b1;
    in_req.opcode  <= op;
    in_req.task_id <= id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait for every owed response.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CountW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin
    logic [TaskW-1:0] fill_ids [QDepth];
    int burst_left;
    int wait_pct;
    int seg;
    int n;

    fill_ids = '{4'd15, 4'd0, 4'd5, 4'd10, 4'd3, 4'd12, 4'd6, 4'd9};
    rst_n <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset settings (initial 0, max 1), no idling.
    send_request(OP_SIGNAL, 4'd9);     // no waiters, count below max: raised
    send_request(OP_SIGNAL, 4'd15);    // count at max: refused
    send_request(OP_WAIT, 4'd0);       // takes the unit
    for (n = 0; n < QDepth; n++)       // count empty: every wait blocks
      send_request(OP_WAIT, fill_ids[n]);
    send_request(OP_WAIT, 4'd7);       // queue full: refused
    for (n = 0; n < QDepth; n++)       // wake in FIFO order; task field ignored
      send_request(OP_SIGNAL, (n % 2) ? 4'd15 : 4'd0);
    send_request(OP_SIGNAL, 4'd0);     // raised
    send_request(OP_WAIT, 4'd15);      // granted
    send_request(OP_WAIT, 4'd2);       // blocked
    send_request(OP_SIGNAL, 4'd6);     // waiter woken though count below max

    // Random bursts: three idling mixes, two segments of register writes each.
    for (seg = 0; seg < 6; seg++) begin
      case (seg / 2)
        0: begin
          send_idle_pct = 19;
          stall_pct     = 80;
        end
        1: begin
          send_idle_pct = 80;
          stall_pct     = 19;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
      endcase

      // registers change only with the block idle
      wait_drained();
      repeat (4) @(posedge clk);
      case (seg)
        0: begin
          cfg_write(REG_MAX_COUNT, 8'd0);
          cfg_write(REG_INITIAL_COUNT, 8'd0);
        end
        1: begin
          cfg_write(REG_INITIAL_COUNT, 8'd255);
          cfg_write(REG_MAX_COUNT, 8'd255);
        end
        2: begin
          cfg_write(REG_INITIAL_COUNT, 8'd200);   // clamped to max below
          cfg_write(REG_MAX_COUNT, 8'd3);
        end
        3: begin
          // unmapped index: count and queue carry over untouched
          cfg_write(REG_SPARE_B, 8'($urandom_range(255)));
        end
        4: begin
          cfg_write(REG_SPARE_A, 8'($urandom_range(255)));
          cfg_write(REG_INITIAL_COUNT, 8'($urandom_range(4)));
          cfg_write(REG_MAX_COUNT, 8'($urandom_range(4)));
        end
        default: begin
          cfg_write(REG_INITIAL_COUNT, 8'($urandom_range(255)));
          cfg_write(REG_MAX_COUNT, 8'($urandom_range(6)));
        end
      endcase

      // Bursts lean toward waits or signals so the count empties, the
      // queue fills and both drain again.
      burst_left = 0;
      wait_pct   = 50;
      for (n = 0; n < SegItems; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          case ($urandom_range(2))
            0:       wait_pct = 90;
            1:       wait_pct = 50;
            default: wait_pct = 10;
          endcase
        end
        burst_left--;
        if (n == SegItems / 2) begin
          wait_drained();   // sender holds off until all responses are back
        end else begin
          while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
          end
        end
        send_request(($urandom_range(99) < wait_pct) ? OP_WAIT : OP_SIGNAL,
                     TaskW'($urandom_range(15)));
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);

    $display("%0d responses checked over six register settings and three idling mixes,",
             sb.checked);
    $display("%0d mismatches", sb.mismatches);
    $display("outcomes: granted %0d, blocked %0d, queue full %0d,",
             sb.seen[OUT_GRANTED], sb.seen[OUT_BLOCKED], sb.seen[OUT_QUEUE_FULL]);
    $display("  woke %0d, raised %0d, count full %0d",
             sb.seen[OUT_WOKE], sb.seen[OUT_RAISED], sb.seen[OUT_COUNT_FULL]);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("timeout with %0d responses still owed", sb.pending());
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: counting_semaphore_fifo_wait.f
src/csfw_pkg.sv
src/counting_semaphore_fifo_wait.sv
verif/tb.sv
